FILE: hdl/dasg_pkg.sv
// shared constants and types for the direction arrow segment generator
`timescale 1ns / 1ps
package dasg_pkg;
    localparam int MAX_ARROWS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam logic [15:0] ARROW_LEN_RST = 16'd2560;
    localparam logic signed [15:0] COS_Q15 = 16'sd30274;
    localparam logic signed [15:0] SIN_Q15 = 16'sd12540;

    // division in progress
    localparam logic [2:0] SEL_UX  = 3'd0;
    localparam logic [2:0] SEL_UY  = 3'd1;
    localparam logic [2:0] SEL_CNT = 3'd2;

    typedef enum logic [1:0] {
        PART_SHAFT = 2'd0,
        PART_LEFT  = 2'd1,
        PART_RIGHT = 2'd2
    } t_part;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start setup
        logic sqrt_step; // one square root iteration
        logic div_step;  // one divider iteration
        logic div_init;  // start a division (sel chooses operand)
        logic [2:0] sel; // ux, uy or arrow count
        logic calc_step; // one offset product
        logic emit_adv;  // advance to next arrow start
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic short_seg;
        logic [5:0] n_arrows;
        logic       truncated;
    } t_sts;
endpackage

FILE: hdl/dasg_ctrl.sv
// controller state machine for the direction arrow segment generator
`timescale 1ns / 1ps
module dasg_ctrl #(
    parameter int MAX_ARROWS = dasg_pkg::MAX_ARROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output dasg_pkg::t_cmd  o_cmd,
    input  dasg_pkg::t_sts  i_sts,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_part,
    output logic            o_last,
    output logic            o_trunc
);
    import dasg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQRT, S_DIV, S_CALC, S_EMIT
    } t_state;

    t_state r_state;
    logic [6:0] r_cnt;
    logic [2:0] r_sel;
    logic [5:0] r_arrow;
    logic [1:0] r_part;
    logic       r_valid;

    wire emit_fire = r_valid && i_out_ready;
    wire final_part = (r_part == PART_RIGHT) &&
                      ({1'b0, r_arrow} + 7'd1 == {1'b0, i_sts.n_arrows});

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.div_init  = (r_state == S_DIV) && (r_cnt == 7'd0);
        o_cmd.div_step  = (r_state == S_DIV) && (r_cnt != 7'd0);
        o_cmd.sel       = r_sel;
        o_cmd.calc_step = (r_state == S_CALC);
        o_cmd.emit_adv  = emit_fire && (r_part == PART_RIGHT);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign o_part      = r_part;
    assign o_last      = final_part;
    assign o_trunc     = final_part && i_sts.truncated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= SEL_UX;
            r_arrow <= '0;
            r_part  <= PART_SHAFT;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SQRT;
                        r_cnt   <= '0;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 7'd31) begin
                        r_cnt <= '0;
                        r_sel <= SEL_UX;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0 && r_sel == SEL_UX && i_sts.short_seg) begin
                        r_state <= S_IDLE;
                    end else if (r_cnt == 7'd64) begin
                        r_cnt <= '0;
                        if (r_sel == SEL_CNT) begin
                            r_state <= S_CALC;
                        end else begin
                            r_sel <= r_sel + 3'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_CALC: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd9) begin
                        r_state <= S_EMIT;
                        r_arrow <= '0;
                        r_part  <= PART_SHAFT;
                        r_valid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        if (final_part) begin
                            r_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (r_part == PART_RIGHT) begin
                            r_part  <= PART_SHAFT;
                            r_arrow <= r_arrow + 6'd1;
                        end else begin
                            r_part <= r_part + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_EMIT) else $error("result outside emit");
    a_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_part != 2'd3) else $error("bad part");
    a_arrow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> {1'b0, r_arrow} < 7'(MAX_ARROWS)) else $error("arrow overrun");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_valid) else $error("ready while emitting");
`endif
endmodule

FILE: hdl/dasg_dp.sv
// datapath: length, unit vector, offsets and arrow coordinates
`timescale 1ns / 1ps
module dasg_dp #(
    parameter int MAX_ARROWS  = dasg_pkg::MAX_ARROWS_DEF,
    parameter int COORD_WIDTH = dasg_pkg::COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_rst_n,
    input  dasg_pkg::t_cmd      i_cmd,
    output dasg_pkg::t_sts      o_sts,
    input  logic [19:0]         i_segment_index,
    input  logic signed [31:0]  i_from_x,
    input  logic signed [31:0]  i_from_y,
    input  logic signed [31:0]  i_to_x,
    input  logic signed [31:0]  i_to_y,
    input  logic [1:0]          i_part,
    output logic [19:0]         o_segment_tag,
    output logic signed [31:0]  o_start_x,
    output logic signed [31:0]  o_start_y,
    output logic signed [31:0]  o_end_x,
    output logic signed [31:0]  o_end_y
);
    import dasg_pkg::*;
    localparam int IB = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int W  = 72;

    logic [15:0] r_alen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_alen <= ARROW_LEN_RST;
        else if (i_cfg_valid) r_alen <= i_cfg_data;
    end
    wire [15:0] a = (r_alen == 16'd0) ? 16'd1 : r_alen;

    logic [19:0] r_tag;
    logic signed [W-1:0] r_fx, r_fy, r_dx, r_dy;
    logic [33:0] r_ax, r_ay;
    logic [2:0]  r_s;
    // square root
    logic [63:0] r_rem, r_root, r_bit;
    logic [33:0] r_len;
    // divider
    logic [50:0] r_num, r_q;
    logic [35:0] r_den;
    logic [51:0] r_drem;
    logic signed [16:0] r_ux, r_uy;
    logic [5:0] r_nar;
    logic r_trunc;
    // offsets
    logic signed [W-1:0] r_shx, r_shy, r_stx, r_sty, r_lx, r_ly, r_rx, r_ry, r_ox, r_oy;
    logic signed [W-1:0] r_px, r_py;
    logic [3:0] r_ci;
    logic signed [35:0] r_m;

    function automatic logic signed [W-1:0] sx(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v << (32 - IB)) >>> (32 - IB);
        return W'(t);
    endfunction

    function automatic logic signed [W-1:0] rnd(input logic signed [W-1:0] p,
                                                input int k);
        return (p + (W'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic logic [31:0] sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi, lo;
        hi = (W'(1) <<< (COORD_WIDTH - 1)) - W'(1);
        lo = -hi - W'(1);
        if (v > hi) return hi[31:0];
        if (v < lo) return lo[31:0];
        return v[31:0];
    endfunction

    wire [33:0] len_full = r_len;
    wire [63:0] trial = r_root + r_bit;
    wire [51:0] drem_sh = {r_drem[50:0], r_num[50]};
    wire [W-1:0] ua = {{(W-34){1'b0}}, a, 18'd0} >> 18;
    wire [33:0] three_a = 34'(a) * 34'd3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_segment_index;
            r_fx  <= sx(i_from_x);
            r_fy  <= sx(i_from_y);
            r_dx  <= sx(i_to_x) - sx(i_from_x);
            r_dy  <= sx(i_to_y) - sx(i_from_y);
            begin : ld
                logic signed [W-1:0] dx, dy;
                logic [33:0] ax, ay;
                dx = sx(i_to_x) - sx(i_from_x);
                dy = sx(i_to_y) - sx(i_from_y);
                ax = dx[W-1] ? 34'(-dx) : 34'(dx);
                ay = dy[W-1] ? 34'(-dy) : 34'(dy);
                if (ax[33] || ay[33]) begin
                    r_s <= 3'd3; ax = ax >> 3; ay = ay >> 3;
                end else if (ax[32] || ay[32]) begin
                    r_s <= 3'd2; ax = ax >> 2; ay = ay >> 2;
                end else if (ax[31] || ay[31]) begin
                    r_s <= 3'd1; ax = ax >> 1; ay = ay >> 1;
                end else r_s <= 3'd0;
                r_ax <= ax; r_ay <= ay;
            end
            r_root <= '0;
            r_bit  <= 64'd1 << 62;
            r_rem  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_bit == (64'd1 << 62)) begin
                // first step also forms the sum of squares
                begin : sq
                    logic [63:0] v;
                    v = 64'(r_ax) * 64'(r_ax) + 64'(r_ay) * 64'(r_ay);
                    if (v >= r_bit) begin
                        r_rem <= v - r_bit; r_root <= r_bit;
                    end else begin
                        r_rem <= v; r_root <= '0;
                    end
                end
            end else if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
            r_len <= 34'(((r_rem >= trial) ? (r_root >> 1) + r_bit : r_root >> 1)
                          << r_s);
        end
        if (i_cmd.div_init) begin
            r_drem <= '0;
            r_q    <= '0;
            unique case (i_cmd.sel)
                SEL_UX: begin
                    r_num <= 51'(r_dx[W-1] ? 34'(-r_dx) : 34'(r_dx)) << 15;
                    r_den <= 36'(len_full);
                end
                SEL_UY: begin
                    r_num <= 51'(r_dy[W-1] ? 34'(-r_dy) : 34'(r_dy)) << 15;
                    r_den <= 36'(len_full);
                end
                default: begin
                    r_num <= 51'(2 * 36'(len_full) - 36'(a) - 36'(three_a));
                    r_den <= 36'(a) * 36'd6;
                end
            endcase
        end
        if (i_cmd.div_step) begin
            if (drem_sh >= 52'(r_den)) begin
                r_drem <= drem_sh - 52'(r_den);
                r_q    <= {r_q[49:0], 1'b1};
            end else begin
                r_drem <= drem_sh;
                r_q    <= {r_q[49:0], 1'b0};
            end
            r_num <= {r_num[49:0], 1'b0};
        end
        if (i_cmd.calc_step) begin
            r_ci <= r_ci + 4'd1;
            unique case (r_ci)
                4'd0: r_m <= 36'(r_ux) * 36'(COS_Q15) + 36'(r_uy) * 36'(SIN_Q15);
                4'd1: begin
                    r_lx <= rnd(W'(r_m) * $signed(ua), 31);
                    r_m  <= 36'(r_uy) * 36'(COS_Q15) - 36'(r_ux) * 36'(SIN_Q15);
                end
                4'd2: begin
                    r_ly <= rnd(W'(r_m) * $signed(ua), 31);
                    r_m  <= 36'(r_ux) * 36'(COS_Q15) - 36'(r_uy) * 36'(SIN_Q15);
                end
                4'd3: begin
                    r_rx <= rnd(W'(r_m) * $signed(ua), 31);
                    r_m  <= 36'(r_uy) * 36'(COS_Q15) + 36'(r_ux) * 36'(SIN_Q15);
                end
                4'd4: r_ry <= rnd(W'(r_m) * $signed(ua), 31);
                4'd5: begin
                    r_shx <= rnd(W'(r_ux) * $signed(ua), 15);
                    r_shy <= rnd(W'(r_uy) * $signed(ua), 15);
                end
                4'd6: begin
                    r_stx <= rnd(W'(r_ux) * $signed(W'(three_a)), 15);
                    r_sty <= rnd(W'(r_uy) * $signed(W'(three_a)), 15);
                end
                4'd7: begin
                    r_ox <= rnd(W'(r_ux) * $signed(ua), 16);
                    r_oy <= rnd(W'(r_uy) * $signed(ua), 16);
                end
                4'd8: begin
                    r_px <= r_fx + r_ox;
                    r_py <= r_fy + r_oy;
                end
                default: ;
            endcase
        end else begin
            r_ci <= '0;
        end
        if (i_cmd.emit_adv) begin
            r_px <= r_px + r_stx;
            r_py <= r_py + r_sty;
        end
    end

    // capture each quotient on the divider step that forms its last bit
    logic [5:0] r_dcnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) r_dcnt <= '0;
        else if (i_cmd.div_step) r_dcnt <= r_dcnt + 6'd1;
        if (i_cmd.div_step && r_dcnt == 6'd50) begin
            begin : qv
                logic [50:0] q;
                logic [15:0] m;
                q = (drem_sh >= 52'(r_den)) ? {r_q[49:0], 1'b1} : {r_q[49:0], 1'b0};
                m = (q > 51'd32767) ? 16'd32767 : q[15:0];
                unique case (i_cmd.sel)
                    SEL_UX: r_ux <= r_dx[W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
                    SEL_UY: r_uy <= r_dy[W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
                    default: begin
                        r_trunc <= (q + 51'd1) > 51'(MAX_ARROWS);
                        r_nar   <= ((q + 51'd1) > 51'(MAX_ARROWS)) ? 6'(MAX_ARROWS)
                                                                   : 6'(q + 51'd1);
                    end
                endcase
            end
        end
    end

    assign o_sts.short_seg = (36'(len_full) < 36'(three_a));
    assign o_sts.n_arrows  = r_nar;
    assign o_sts.truncated = r_trunc;

    wire signed [W-1:0] ex = r_px + r_shx;
    wire signed [W-1:0] ey = r_py + r_shy;
    always_comb begin
        o_segment_tag = r_tag;
        unique case (i_part)
            PART_SHAFT: begin
                o_start_x = sat(r_px); o_start_y = sat(r_py);
                o_end_x = sat(ex); o_end_y = sat(ey);
            end
            PART_LEFT: begin
                o_start_x = sat(ex); o_start_y = sat(ey);
                o_end_x = sat(ex - r_lx); o_end_y = sat(ey - r_ly);
            end
            default: begin
                o_start_x = sat(ex); o_start_y = sat(ey);
                o_end_x = sat(ex - r_rx); o_end_y = sat(ey - r_ry);
            end
        endcase
    end
endmodule

FILE: hdl/direction_arrow_segment_generator_unit.sv
// top level of the direction arrow segment generator
//  channel | direction | handshake                  | carries
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | arrow length
//  in      | in        | i_valid / o_ready          | segment request
//  out     | out       | o_valid / i_ready          | shaft or barb line
// a request runs the square root, then (if not short) 3 divisions and offset steps,
// then 3 results per arrow, one a cycle while i_ready is high
// the serial square root and the shared restoring divider set the setup time
// reset is synchronous, active low, and sets arrow length to 2560
// a stalled output holds the result and the block takes no new request
`timescale 1ns / 1ps
module direction_arrow_segment_generator_unit #(
    parameter int MAX_ARROWS  = dasg_pkg::MAX_ARROWS_DEF,
    parameter int COORD_WIDTH = dasg_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_arrow_len,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_segment_index,
    input  logic signed [31:0] i_from_x,
    input  logic signed [31:0] i_from_y,
    input  logic signed [31:0] i_to_x,
    input  logic signed [31:0] i_to_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [19:0]        o_segment_tag,
    output logic signed [31:0] o_start_x,
    output logic signed [31:0] o_start_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic [1:0]         o_part,
    output logic               o_last,
    output logic               o_truncated
);
    import dasg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // register is always writable
    assign o_cfg_ready = 1'b1;

    dasg_ctrl #(.MAX_ARROWS(MAX_ARROWS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .o_cmd(w_cmd), .i_sts(w_sts),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .o_part, .o_last, .o_trunc(o_truncated)
    );

    dasg_dp #(.MAX_ARROWS(MAX_ARROWS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_data(i_cfg_arrow_len),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_segment_index, .i_from_x, .i_from_y, .i_to_x, .i_to_y,
        .i_part(o_part),
        .o_segment_tag, .o_start_x, .o_start_y, .o_end_x, .o_end_y
    );

`ifndef SYNTHESIS
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_truncated |-> o_last) else $error("truncated without last");
    a_last_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_part == PART_RIGHT) else $error("last not barb");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while busy");
`endif
endmodule

FILE: bench/arrow_line_checker.sv
// checker for the arrow generator: predicts the drawn lines and compares the output channel
`timescale 1ns / 1ps
module arrow_line_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_arrow_len,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [19:0]        i_segment_index,
    input  logic signed [31:0] i_from_x,
    input  logic signed [31:0] i_from_y,
    input  logic signed [31:0] i_to_x,
    input  logic signed [31:0] i_to_y,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [19:0]        i_segment_tag,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic [1:0]         i_part,
    input  logic               i_last,
    input  logic               i_truncated,
    output int                 o_fail_count,
    output int                 o_lines_pending
);
    import dasg_pkg::*;

    localparam int MAX_ARROWS = MAX_ARROWS_DEF;

    typedef struct {
        logic [19:0]        tag;
        logic signed [31:0] sx, sy, ex, ey;
        t_part              part;
        logic               last, trunc;
    } t_line;

    t_line       expected_lines[$];
    logic [15:0] arrow_len_q;

    function automatic longint round_shift(longint p, int k);
        return (p + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(longint d, longint unsigned len);
        longint unsigned mag, m;
        mag = (d < 0) ? -d : d;
        m = (mag << 15) / len;
        if (m > 32767) m = 32767;
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // queue every line that one segment request should produce
    task automatic predict_arrows(logic [19:0] tag, longint fx, longint fy,
                                  longint tx, longint ty);
        longint dx, dy, a, ux, uy, shx, shy, stx, sty, lx, ly, rx, ry, cx, cy, px, py;
        longint unsigned ax, ay, len, nar;
        int s;
        t_line ln;
        dx = tx - fx;
        dy = ty - fy;
        a = (arrow_len_q == 0) ? 1 : arrow_len_q;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s = 0;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax >>= 1;
            ay >>= 1;
            s++;
        end
        len = int_sqrt(ax * ax + ay * ay) << s;
        // short or zero length segments draw nothing
        if (len < 3 * a) return;
        ux = unit_component(dx, len);
        uy = unit_component(dy, len);
        nar = (2 * len - 4 * a) / (6 * a) + 1;
        shx = round_shift(ux * a, 15);
        shy = round_shift(uy * a, 15);
        stx = round_shift(ux * 3 * a, 15);
        sty = round_shift(uy * 3 * a, 15);
        lx = round_shift((ux * COS_Q15 + uy * SIN_Q15) * a, 31);
        ly = round_shift((uy * COS_Q15 - ux * SIN_Q15) * a, 31);
        rx = round_shift((ux * COS_Q15 - uy * SIN_Q15) * a, 31);
        ry = round_shift((uy * COS_Q15 + ux * SIN_Q15) * a, 31);
        cx = fx + round_shift(ux * a, 16);
        cy = fy + round_shift(uy * a, 16);
        ln.tag = tag;
        ln.last = 1'b0;
        ln.trunc = 1'b0;
        for (longint unsigned n = 0; n < nar && n < MAX_ARROWS; n++) begin
            px = cx + shx;
            py = cy + shy;
            ln.sx = clamp_coord(cx); ln.sy = clamp_coord(cy);
            ln.ex = clamp_coord(px); ln.ey = clamp_coord(py);
            ln.part = PART_SHAFT;
            expected_lines.insert(expected_lines.size(), ln);
            ln.sx = clamp_coord(px); ln.sy = clamp_coord(py);
            ln.ex = clamp_coord(px - lx); ln.ey = clamp_coord(py - ly);
            ln.part = PART_LEFT;
            expected_lines.insert(expected_lines.size(), ln);
            ln.ex = clamp_coord(px - rx); ln.ey = clamp_coord(py - ry);
            ln.part = PART_RIGHT;
            expected_lines.insert(expected_lines.size(), ln);
            cx += stx;
            cy += sty;
        end
        expected_lines[$].last = 1'b1;
        expected_lines[$].trunc = (nar > MAX_ARROWS);
    endtask

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
    endtask

    initial begin
        o_fail_count = 0;
        o_lines_pending = 0;
        arrow_len_q = ARROW_LEN_RST;
    end

    always @(posedge i_clk) begin
        t_line e;
        if (!i_rst_n) begin
            arrow_len_q = ARROW_LEN_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) arrow_len_q = i_cfg_arrow_len;
            if (i_in_valid && i_in_ready)
                predict_arrows(i_segment_index, i_from_x, i_from_y, i_to_x, i_to_y);
            if (i_out_valid && i_out_ready) begin
                if (expected_lines.size() == 0) begin
                    report("unexpected line, tag", 0, i_segment_tag);
                end else begin
                    e = expected_lines.pop_front();
                    if (e.tag !== i_segment_tag) report("segment_tag", e.tag, i_segment_tag);
                    if (e.sx !== i_start_x) report("start_x", e.sx, i_start_x);
                    if (e.sy !== i_start_y) report("start_y", e.sy, i_start_y);
                    if (e.ex !== i_end_x) report("end_x", e.ex, i_end_x);
                    if (e.ey !== i_end_y) report("end_y", e.ey, i_end_y);
                    if (e.part !== i_part) report("part", e.part, i_part);
                    if (e.last !== i_last) report("last", e.last, i_last);
                    if (e.trunc !== i_truncated) report("truncated", e.trunc, i_truncated);
                end
            end
        end
        o_lines_pending = expected_lines.size();
    end
endmodule

FILE: bench/tb.sv
// testbench top for the direction arrow segment generator: stimulus and verdict
`timescale 1ns / 1ps
module tb;
    localparam int  LIMIT  = 2000000;
    // SETTLE covers the setup of a request, with margin for requests that draw nothing
    localparam int  SETTLE = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_len = '0;
    logic               seg_valid = 1'b0;
    logic               seg_ready;
    logic [19:0]        seg_index = '0;
    logic signed [31:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
    logic               line_valid;
    logic               line_ready = 1'b0;
    logic [19:0]        line_tag;
    logic signed [31:0] line_sx, line_sy, line_ex, line_ey;
    logic [1:0]         line_part;
    logic               line_last, line_trunc;
    int                 fail_count, lines_pending;
    int                 cycle_count = 0;
    bit                 steady = 1'b0;   // when set neither side idles
    int unsigned        arrow_a = 2560;  // arrow length now in force, shapes the stimulus

    always #6 i_clk = ~i_clk;

    direction_arrow_segment_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_arrow_len(cfg_len),
        .i_valid(seg_valid), .o_ready(seg_ready), .i_segment_index(seg_index),
        .i_from_x(from_x), .i_from_y(from_y), .i_to_x(to_x), .i_to_y(to_y),
        .o_valid(line_valid), .i_ready(line_ready), .o_segment_tag(line_tag),
        .o_start_x(line_sx), .o_start_y(line_sy), .o_end_x(line_ex), .o_end_y(line_ey),
        .o_part(line_part), .o_last(line_last), .o_truncated(line_trunc)
    );

    arrow_line_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_arrow_len(cfg_len),
        .i_in_valid(seg_valid), .i_in_ready(seg_ready), .i_segment_index(seg_index),
        .i_from_x(from_x), .i_from_y(from_y), .i_to_x(to_x), .i_to_y(to_y),
        .i_out_valid(line_valid), .i_out_ready(line_ready), .i_segment_tag(line_tag),
        .i_start_x(line_sx), .i_start_y(line_sy), .i_end_x(line_ex), .i_end_y(line_ey),
        .i_part(line_part), .i_last(line_last), .i_truncated(line_trunc),
        .o_fail_count(fail_count), .o_lines_pending(lines_pending)
    );

    // receiver stalls at random, changes at the falling edge
    always @(negedge i_clk)
        line_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("** direction_arrow_segment_generator_unit: FAILED **");
            $finish;
        end
    end

    // one segment request, with a random gap in front of it
    task automatic send_segment(logic [19:0] idx, logic signed [31:0] fx,
                                logic signed [31:0] fy, logic signed [31:0] tx,
                                logic signed [31:0] ty);
        while (!steady && $urandom_range(0, 99) < 36) @(negedge i_clk);
        seg_valid = 1'b1;
        seg_index = idx;
        from_x = fx; from_y = fy; to_x = tx; to_y = ty;
        @(posedge i_clk);
        while (!seg_ready) @(posedge i_clk);
        @(negedge i_clk);
        seg_valid = 1'b0;
    endtask

    // hold off until every line has come out and the block has settled
    task automatic drain();
        while (lines_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_arrow_len(logic [15:0] v);
        cfg_valid = 1'b1;
        cfg_len = v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        arrow_a = (v == 0) ? 1 : v;
    endtask

    // mostly well-formed segments sized in arrow lengths, some full range noise
    task automatic random_segment();
        longint lt, dx, dy, fx, fy;
        real    th;
        if ($urandom_range(0, 99) < 20) begin
            send_segment(20'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
        end else begin
            lt = longint'($urandom_range(0, 40)) * arrow_a + $urandom_range(0, arrow_a);
            if (lt > 64'd1000000000) lt = 64'd1000000000;
            th = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            dx = $rtoi(lt * $cos(th));
            dy = $rtoi(lt * $sin(th));
            fx = longint'(int'($urandom()) >>> 2);
            fy = longint'(int'($urandom()) >>> 2);
            send_segment(20'($urandom()), 32'(fx), 32'(fy), 32'(fx + dx), 32'(fy + dy));
        end
    endtask

    initial begin
        logic signed [31:0] big, neg;
        big = 32'sh7fffffff;
        neg = 32'sh80000000;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset arrow length
        send_segment(20'h0, 0, 0, 0, 0);                     // zero length
        send_segment(20'hfffff, 0, 0, 3 * 2560 - 1, 0);      // just too short
        send_segment(20'h12345, 0, 0, 3 * 2560, 0);          // one arrow exactly
        send_segment(20'h1, 100, -200, 100, 60000);          // along y
        send_segment(20'h2, 5000, 0, -50000, -50000);        // negative diagonal
        send_segment(20'h3, neg, neg, big, big);             // full span, truncated
        send_segment(20'h4, big, neg, neg, big);
        send_segment(20'h5, big, 0, big, 40000);             // barbs saturate in x
        send_segment(20'h6, 0, neg, -40000, neg);            // barbs saturate in y
        send_segment(20'h7, 0, 0, 6 * 2560 * 16, 0);         // beyond the arrow limit, truncated
        send_segment(20'h8, 0, 0, 6 * 2560 * 17, 1);
        drain();

        write_arrow_len(16'd1);                              // smallest length
        send_segment(20'h9, 0, 0, 2, 0);
        send_segment(20'ha, 0, 0, 3, 0);
        send_segment(20'hb, -7, 9, 200, -300);
        drain();
        write_arrow_len(16'd0);                              // zero behaves as one
        send_segment(20'hc, 0, 0, 0, 3);
        send_segment(20'hd, 1, 1, -60, -80);
        drain();
        write_arrow_len(16'hffff);                           // largest length
        send_segment(20'he, 0, 0, 3 * 65535, 0);
        send_segment(20'hf, neg, 0, big, 0);
        send_segment(20'h10, 0, big, 0, neg);
        drain();

        // random phases over several lengths
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_arrow_len(16'd2560);
                1: write_arrow_len(16'd1);
                2: write_arrow_len(16'hffff);
                3: write_arrow_len(16'($urandom_range(2, 65534)));
                4: write_arrow_len(16'd0);
                default: write_arrow_len(16'($urandom_range(1, 4000)));
            endcase
            for (int n = 0; n < 44; n++) begin
                steady = (ph == 0 && n >= 10 && n < 30);
                random_segment();
            end
            steady = 1'b0;
            drain();
        end

        while (lines_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && lines_pending == 0)
            $display("** direction_arrow_segment_generator_unit: PASSED **");
        else
            $display("** direction_arrow_segment_generator_unit: FAILED **");
        $finish;
    end
endmodule

FILE: sim.f
hdl/dasg_pkg.sv
hdl/dasg_ctrl.sv
hdl/dasg_dp.sv
hdl/direction_arrow_segment_generator_unit.sv
bench/arrow_line_checker.sv
bench/tb.sv
